// File: hdl/skf_pkg.sv
// skf_pkg: widths, register codes, microcode fields and the program rom of
// the scalar kalman filter core; depends on nothing else
package skf_pkg;

    localparam int DATA_WIDTH_DEFAULT = 32;

    // q8.24 covariance and q1.24 gain formats
    localparam int COV_W  = 32;
    localparam int FRAC_W = 24;
    localparam int GAIN_W = FRAC_W + 1;
    localparam int DEN_W  = COV_W + 1;
    localparam int REM_W  = COV_W + 2;

    localparam logic [GAIN_W-1:0] GAIN_ONE  = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [FRAC_W-1:0] FRAC_HALF = {1'b1, {(FRAC_W - 1){1'b0}}};

    // shared multiplier operand widths
    localparam int MUL_A_W = GAIN_W;
    localparam int MUL_B_W = COV_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEASUREMENT_NOISE = 8'd1;

    localparam logic [CFG_DATA_W-1:0] PROCESS_NOISE_RESET     = 32'd16777;
    localparam logic [CFG_DATA_W-1:0] MEASUREMENT_NOISE_RESET = 32'd1677722;

    // microcode
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_LOAD  = 4'd0;
    localparam step_t STEP_PREP  = 4'd1;
    localparam step_t STEP_DIV   = 4'd2;
    localparam step_t STEP_GAIN  = 4'd3;
    localparam step_t STEP_MULP  = 4'd4;
    localparam step_t STEP_COV   = 4'd5;
    localparam step_t STEP_MULD  = 4'd6;
    localparam step_t STEP_ACC   = 4'd7;
    localparam step_t STEP_ROUND = 4'd8;
    localparam step_t STEP_OUT   = 4'd9;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_PREP,
        OP_DIV,
        OP_GAIN,
        OP_MULP,
        OP_COV,
        OP_MULD,
        OP_ACC,
        OP_ROUND,
        OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_NO_INPUT,
        HOLD_OUT_BUSY
    } hold_t;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_ALWAYS,
        JMP_COUNT_NZ
    } jump_t;

    typedef struct packed {
        op_t   op;
        hold_t hold;
        jump_t jump;
        step_t target;
    } ctrl_word_t;

    // program rom
    function automatic ctrl_word_t microcode(input step_t step);
        ctrl_word_t w;
        w = '{op: OP_LOAD, hold: HOLD_NO_INPUT, jump: JMP_NONE, target: STEP_LOAD};
        case (step)
            STEP_LOAD:  w = '{op: OP_LOAD,  hold: HOLD_NO_INPUT, jump: JMP_NONE,
                              target: STEP_LOAD};
            STEP_PREP:  w = '{op: OP_PREP,  hold: HOLD_NONE, jump: JMP_NONE,
                              target: STEP_LOAD};
            STEP_DIV:   w = '{op: OP_DIV,   hold: HOLD_NONE, jump: JMP_COUNT_NZ,
                              target: STEP_DIV};
            STEP_GAIN:  w = '{op: OP_GAIN,  hold: HOLD_NONE, jump: JMP_NONE,
                              target: STEP_LOAD};
            STEP_MULP:  w = '{op: OP_MULP,  hold: HOLD_NONE, jump: JMP_NONE,
                              target: STEP_LOAD};
            STEP_COV:   w = '{op: OP_COV,   hold: HOLD_NONE, jump: JMP_NONE,
                              target: STEP_LOAD};
            STEP_MULD:  w = '{op: OP_MULD,  hold: HOLD_NONE, jump: JMP_NONE,
                              target: STEP_LOAD};
            STEP_ACC:   w = '{op: OP_ACC,   hold: HOLD_NONE, jump: JMP_COUNT_NZ,
                              target: STEP_MULD};
            STEP_ROUND: w = '{op: OP_ROUND, hold: HOLD_NONE, jump: JMP_NONE,
                              target: STEP_LOAD};
            STEP_OUT:   w = '{op: OP_OUT,   hold: HOLD_OUT_BUSY, jump: JMP_ALWAYS,
                              target: STEP_LOAD};
            default:    w = '{op: OP_LOAD,  hold: HOLD_NO_INPUT, jump: JMP_NONE,
                              target: STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

// File: hdl/scalar_kalman_filter_core.sv
// scalar_kalman_filter_core: one-dimensional kalman filter run by a small
// microcode program over a shared divider step and a shared multiplier
// depends on skf_pkg
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   input   | in_valid, in_ready, measurement          | in
//   output  | out_valid, out_ready, estimate, gain     | out
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data| in
//
// one measurement holds the sequencer from its accept to the next accept; out_valid
// rises as the sequencer returns to its first step, before that next accept; the
// restoring gain division makes 25 quotient bits, one quotient bit a cycle, and each
// 24-bit digit of |z - x| goes through the shared 25 x 32 multiplier and the
// accumulator
// reset clears the estimate, the covariance and the sequencer, and loads the
// noise registers with their defaults; cfg_ready is always high
// a result waits in the output register; the sequencer takes the next
// measurement right away and stalls only at its last step while the output
// register is still full
module scalar_kalman_filter_core #(
    parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [DATA_WIDTH-1:0]       measurement,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [DATA_WIDTH-1:0]       estimate,
    output logic [skf_pkg::GAIN_W-1:0]         gain,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [skf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [skf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // |z - x| needs one bit more than the data, split into 24-bit digits
    localparam int MAG_W      = DATA_WIDTH + 1;
    localparam int DIGIT_W    = skf_pkg::FRAC_W;
    localparam int NUM_DIGITS = (MAG_W + DIGIT_W - 1) / DIGIT_W;
    localparam int MAG_PAD_W  = NUM_DIGITS * DIGIT_W;
    localparam int ACC_W      = MAG_PAD_W + skf_pkg::GAIN_W;
    localparam int CNT_MAX    = (NUM_DIGITS > skf_pkg::GAIN_W) ? NUM_DIGITS
                                                               : skf_pkg::GAIN_W;
    localparam int CNT_W      = $clog2(CNT_MAX);
    localparam int EXT_W      = DATA_WIDTH + 2;

    // control word of the current step
    skf_pkg::ctrl_word_t ctrl;

    // sequencer and control state
    skf_pkg::step_t step_reg, step_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic out_valid_reg, out_valid_next;

    // filter state and configuration
    logic signed [DATA_WIDTH-1:0] x_reg, x_next;
    logic [skf_pkg::COV_W-1:0] cov_reg, cov_next;
    logic [skf_pkg::CFG_DATA_W-1:0] q_reg, q_next;
    logic [skf_pkg::CFG_DATA_W-1:0] r_reg, r_next;

    // datapath registers
    logic [skf_pkg::COV_W-1:0] pp_reg, pp_next;
    logic [skf_pkg::DEN_W-1:0] den_reg, den_next;
    logic [skf_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [skf_pkg::GAIN_W-1:0] quo_reg, quo_next;
    logic neg_reg, neg_next;
    logic [MAG_PAD_W-1:0] mag_reg, mag_next;
    logic [skf_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [MAG_W-1:0] scaled_reg, scaled_next;
    logic signed [DATA_WIDTH-1:0] estimate_reg, estimate_next;
    logic [skf_pkg::GAIN_W-1:0] gain_reg, gain_next;

    // combinational helpers
    logic out_busy;
    logic hold_active;
    logic jump_taken;
    logic [skf_pkg::COV_W:0] pp_sum;
    logic [MAG_W-1:0] diff;
    logic [MAG_W-1:0] diff_mag;
    logic div_ge;
    logic [skf_pkg::REM_W-1:0] rem_sub;
    logic [skf_pkg::MUL_A_W-1:0] mul_a;
    logic [skf_pkg::MUL_B_W-1:0] mul_b;
    logic [ACC_W-1:0] round_sum;
    logic [EXT_W-1:0] nx;

    assign ctrl      = skf_pkg::microcode(step_reg);
    assign out_busy  = out_valid_reg && !out_ready;
    assign in_ready  = (ctrl.op == skf_pkg::OP_LOAD);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign estimate  = estimate_reg;
    assign gain      = gain_reg;

    // sequencer: hold, then jump, else fall through to the next step
    always_comb
    begin
        case (ctrl.hold)
            skf_pkg::HOLD_NO_INPUT: hold_active = !in_valid;
            skf_pkg::HOLD_OUT_BUSY: hold_active = out_busy;
            default:                hold_active = 1'b0;
        endcase

        case (ctrl.jump)
            skf_pkg::JMP_ALWAYS:   jump_taken = 1'b1;
            skf_pkg::JMP_COUNT_NZ: jump_taken = (count_reg != '0);
            default:               jump_taken = 1'b0;
        endcase

        if (hold_active)
        begin
            step_next = step_reg;
        end
        else if (jump_taken)
        begin
            step_next = ctrl.target;
        end
        else
        begin
            step_next = step_reg + skf_pkg::step_t'(1);
        end
    end

    // shared multiplier operands: covariance update or the gain times one magnitude digit
    always_comb
    begin
        if (ctrl.op == skf_pkg::OP_MULP)
        begin
            mul_a = skf_pkg::GAIN_ONE - quo_reg;
            mul_b = pp_reg;
        end
        else
        begin
            mul_a = quo_reg;
            mul_b = skf_pkg::MUL_B_W'(mag_reg[MAG_PAD_W-1 -: DIGIT_W]);
        end
    end

    // datapath arithmetic
    always_comb
    begin
        // predicted covariance with a carry bit, saturated when it is loaded
        pp_sum = {1'b0, cov_reg} + {1'b0, q_reg};

        // innovation z - x and its magnitude
        diff     = {measurement[DATA_WIDTH-1], measurement} - {x_reg[DATA_WIDTH-1], x_reg};
        diff_mag = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;

        // restoring division step
        div_ge  = (rem_reg >= {1'b0, den_reg});
        rem_sub = rem_reg - {1'b0, den_reg};

        // round to nearest, ties away from zero, on the magnitude
        round_sum = acc_reg + ACC_W'(skf_pkg::FRAC_HALF);

        // new estimate, two guard bits for the clamp
        if (neg_reg)
        begin
            nx = {x_reg[DATA_WIDTH-1], x_reg[DATA_WIDTH-1], x_reg} - {1'b0, scaled_reg};
        end
        else
        begin
            nx = {x_reg[DATA_WIDTH-1], x_reg[DATA_WIDTH-1], x_reg} + {1'b0, scaled_reg};
        end
    end

    // datapath next state, one operation per control word
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        x_next         = x_reg;
        cov_next       = cov_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        pp_next        = pp_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        scaled_next    = scaled_reg;
        estimate_next  = estimate_reg;
        gain_next      = gain_reg;

        // register writes, unknown indexes dropped
        if (cfg_valid)
        begin
            case (cfg_index)
                skf_pkg::REG_PROCESS_NOISE:     q_next = cfg_data;
                skf_pkg::REG_MEASUREMENT_NOISE: r_next = cfg_data;
                default:                        ;
            endcase
        end

        if (ctrl.jump == skf_pkg::JMP_COUNT_NZ && count_reg != '0)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        case (ctrl.op)
            skf_pkg::OP_LOAD:
            begin
                if (in_valid)
                begin
                    pp_next  = pp_sum[skf_pkg::COV_W] ? '1 : pp_sum[skf_pkg::COV_W-1:0];
                    neg_next = diff[MAG_W-1];
                    mag_next = MAG_PAD_W'(diff_mag);
                end
            end
            skf_pkg::OP_PREP:
            begin
                den_next   = {1'b0, pp_reg} + {1'b0, r_reg};
                rem_next   = skf_pkg::REM_W'(pp_reg);
                quo_next   = '0;
                count_next = CNT_W'(skf_pkg::GAIN_W - 1);
            end
            skf_pkg::OP_DIV:
            begin
                rem_next = (div_ge ? rem_sub : rem_reg) << 1;
                quo_next = {quo_reg[skf_pkg::GAIN_W-2:0], div_ge};
            end
            skf_pkg::OP_GAIN:
            begin
                // zero divisor gives zero gain
                if (den_reg == '0)
                begin
                    quo_next = '0;
                end
            end
            skf_pkg::OP_MULP:
            begin
                prod_next = mul_a * mul_b;
                acc_next  = '0;
            end
            skf_pkg::OP_COV:
            begin
                cov_next   = prod_reg[skf_pkg::FRAC_W +: skf_pkg::COV_W];
                count_next = CNT_W'(NUM_DIGITS - 1);
            end
            skf_pkg::OP_MULD:
            begin
                prod_next = mul_a * mul_b;
                mag_next  = mag_reg << DIGIT_W;
            end
            skf_pkg::OP_ACC:
            begin
                // horner accumulation, most significant digit first
                acc_next = (acc_reg << DIGIT_W) + ACC_W'(prod_reg);
            end
            skf_pkg::OP_ROUND:
            begin
                scaled_next = round_sum[DIGIT_W +: MAG_W];
            end
            skf_pkg::OP_OUT:
            begin
                if (!out_busy)
                begin
                    if (nx[EXT_W-1:DATA_WIDTH-1] != '0 && nx[EXT_W-1:DATA_WIDTH-1] != '1)
                    begin
                        // clamp to the signed data range
                        x_next = nx[EXT_W-1] ? {1'b1, {(DATA_WIDTH - 1){1'b0}}}
                                             : {1'b0, {(DATA_WIDTH - 1){1'b1}}};
                    end
                    else
                    begin
                        x_next = nx[DATA_WIDTH-1:0];
                    end
                    estimate_next  = x_next;
                    gain_next      = quo_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state, filter state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= skf_pkg::STEP_LOAD;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            cov_reg       <= '0;
            q_reg         <= skf_pkg::PROCESS_NOISE_RESET;
            r_reg         <= skf_pkg::MEASUREMENT_NOISE_RESET;
        end
        else
        begin
            step_reg      <= step_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            x_reg         <= x_next;
            cov_reg       <= cov_next;
            q_reg         <= q_next;
            r_reg         <= r_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pp_reg       <= pp_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        scaled_reg   <= scaled_next;
        estimate_reg <= estimate_next;
        gain_reg     <= gain_next;
    end

endmodule

// File: verif/testbench.sv
// testbench for scalar_kalman_filter_core: directed and random measurement streams
// with random idling on both channels, checked against an in-bench kalman predictor
// depends on skf_pkg and scalar_kalman_filter_core
module testbench;

    localparam int DW = skf_pkg::DATA_WIDTH_DEFAULT;

    // estimate bounds as 64-bit signed values, used for the final clamp
    localparam logic signed [63:0] EST_MAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
    localparam logic signed [63:0] EST_MIN = -(64'sd1 <<< (DW - 1));

    localparam logic [32:0] COV_SAT = 33'h0_FFFF_FFFF;
    localparam logic [31:0] NOISE_MAX = 32'hFFFF_FFFF;

    // one predicted output transaction
    typedef struct packed {
        logic signed [DW-1:0]          estimate;
        logic [skf_pkg::GAIN_W-1:0]    gain;
    } filter_result_t;

    // clock, reset and dut-facing signals; those the bench drives are known from time zero
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic signed [DW-1:0]                 measurement = '0;

    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic signed [DW-1:0]                 estimate;
    logic [skf_pkg::GAIN_W-1:0]           gain;

    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [skf_pkg::CFG_INDEX_W-1:0]      cfg_index = '0;
    logic [skf_pkg::CFG_DATA_W-1:0]       cfg_data = '0;

    // predictor state: a private copy of the filter and its noise registers
    logic signed [DW-1:0] model_estimate;
    logic [31:0]          model_covariance;
    logic [31:0]          model_q;
    logic [31:0]          model_r;

    // results predicted for accepted measurements, oldest first
    filter_result_t predicted_results[$];

    int unsigned mismatch_count = 0;

    // when set, the matching side never idles
    bit src_steady = 1'b0;
    bit sink_steady = 1'b0;

    scalar_kalman_filter_core #(
        .DATA_WIDTH(DW)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .measurement(measurement),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .estimate   (estimate),
        .gain       (gain),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 10 unit period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one filter step: predict covariance, form the gain, move the estimate
    // toward the sample and shrink the covariance; updates the predictor state
    task automatic kalman_update(input logic signed [DW-1:0] z, output filter_result_t res);
        logic [32:0]                   pp;
        logic [32:0]                   den;
        logic [63:0]                   quot;
        logic [skf_pkg::GAIN_W-1:0]    g;
        logic signed [63:0]            z64;
        logic signed [63:0]            x64;
        logic signed [63:0]            diff;
        logic signed [63:0]            nx;
        logic [63:0]                   mag;
        logic [63:0]                   delta;
        logic [63:0]                   cov;
        // predicted covariance saturates at the 32-bit maximum
        pp = {1'b0, model_covariance} + {1'b0, model_q};
        if (pp > COV_SAT)
            pp = COV_SAT;
        // the divisor is 33 bits and not saturated
        den = pp + {1'b0, model_r};
        quot = 64'd0;
        if (den != 33'd0)
            quot = ({31'd0, pp} << skf_pkg::FRAC_W) / {31'd0, den};
        if (quot > {39'd0, skf_pkg::GAIN_ONE})
            quot = {39'd0, skf_pkg::GAIN_ONE};
        g = quot[skf_pkg::GAIN_W-1:0];

        // interpolate with round to nearest, ties away from zero
        z64 = z;
        x64 = model_estimate;
        diff = z64 - x64;
        mag = (diff >= 0) ? diff : -diff;
        delta = (mag >> skf_pkg::FRAC_W) * {39'd0, g}
              + (((mag & 64'h00FF_FFFF) * {39'd0, g} + {40'd0, skf_pkg::FRAC_HALF})
                 >> skf_pkg::FRAC_W);
        if (diff >= 0)
            nx = x64 + delta;
        else
            nx = x64 - delta;
        if (nx < EST_MIN)
            nx = EST_MIN;
        if (nx > EST_MAX)
            nx = EST_MAX;

        cov = (({39'd0, skf_pkg::GAIN_ONE} - {39'd0, g}) * {31'd0, pp}) >> skf_pkg::FRAC_W;

        model_estimate = nx[DW-1:0];
        model_covariance = cov[31:0];
        res.estimate = nx[DW-1:0];
        res.gain = g;
    endtask

    // present one measurement, hold it until accepted, record its prediction;
    // valid is left high so the next call can follow back to back
    task automatic send_measurement(input logic signed [DW-1:0] z);
        filter_result_t res;
        while (!src_steady && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        measurement <= z;
        do
            @(posedge clk);
        while (!in_ready);
        kalman_update(z, res);
        predicted_results.push_back(res);
    endtask

    // drop valid and wait until every predicted result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one register write transaction; unknown indexes leave the predictor alone
    task automatic write_reg(input logic [skf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == skf_pkg::REG_PROCESS_NOISE)
            model_q = data;
        else if (idx == skf_pkg::REG_MEASUREMENT_NOISE)
            model_r = data;
        cfg_valid <= 1'b0;
        // keep the next write's valid rise in a later time step
        @(posedge clk);
    endtask

    // noise value mix: extremes, small, around 1.0 and full range
    function automatic logic [31:0] pick_noise();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return NOISE_MAX;
            2: return 32'($urandom_range(0, 65535));
            3: return 32'($urandom_range(0, 33554432));
            default: return $urandom;
        endcase
    endfunction

    // sample mix: mostly noisy readings around a setpoint, some noise, some extremes
    function automatic logic signed [DW-1:0] pick_measurement(input logic signed [DW-1:0] center);
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3, 4: return $urandom;
            // +-2.0 of jitter in q16.16
            default: return center + {{14{r[17]}}, r[17:0]};
        endcase
    endfunction

    // default noise registers straight after reset, field extremes
    task automatic test_reset_defaults();
        send_measurement(32'sd0);
        send_measurement(32'sh7FFF_FFFF);
        send_measurement(32'sh8000_0000);
        send_measurement(32'sd1);
        send_measurement(-32'sd1);
        wait_drained();
    endtask

    // r = 0: gain is exactly 1.0 and the estimate follows the sample, full swings
    task automatic test_zero_measurement_noise();
        write_reg(skf_pkg::REG_PROCESS_NOISE, 32'd16777);
        write_reg(skf_pkg::REG_MEASUREMENT_NOISE, 32'd0);
        send_measurement(32'sh7FFF_FFFF);
        send_measurement(32'sh8000_0000);
        send_measurement(32'sh7FFF_FFFF);
        send_measurement(32'sh0001_8000);
        wait_drained();
    endtask

    // q = r = 0 with covariance already cleared: zero divisor, gain 0, nothing moves
    task automatic test_zero_divisor();
        write_reg(skf_pkg::REG_PROCESS_NOISE, 32'd0);
        send_measurement(32'sh1234_5678);
        send_measurement(32'sh8000_0000);
        send_measurement(32'sh7FFF_FFFF);
        wait_drained();
    endtask

    // maximum noise so that p + q saturates, then max q against zero r
    task automatic test_covariance_saturation();
        write_reg(skf_pkg::REG_PROCESS_NOISE, NOISE_MAX);
        write_reg(skf_pkg::REG_MEASUREMENT_NOISE, NOISE_MAX);
        send_measurement(32'sh7FFF_FFFF);
        send_measurement(32'sh8000_0000);
        send_measurement(32'sh4000_0000);
        wait_drained();
        write_reg(skf_pkg::REG_MEASUREMENT_NOISE, 32'd0);
        send_measurement(-32'sh0000_0001);
        wait_drained();
    endtask

    // writes to indexes with no register behind them must not disturb anything
    task automatic test_unknown_index();
        write_reg(skf_pkg::REG_PROCESS_NOISE, skf_pkg::PROCESS_NOISE_RESET);
        write_reg(skf_pkg::REG_MEASUREMENT_NOISE, skf_pkg::MEASUREMENT_NOISE_RESET);
        write_reg(8'd2, 32'h0000_0000);
        write_reg(8'hFF, NOISE_MAX);
        write_reg(8'h80, 32'h5A5A_A5A5);
        send_measurement(32'sh0010_0000);
        send_measurement(32'sh0010_4000);
        send_measurement(-32'sh0003_0000);
        wait_drained();
    endtask

    // random phases: fresh noise settings, then a noisy stream around a setpoint
    task automatic test_random_streams();
        int unsigned total;
        int unsigned count;
        int unsigned phase;
        logic signed [DW-1:0] center;
        total = 0;
        phase = 0;
        while (total < 1600)
        begin
            // stray writes to unused indexes, then the real registers in random order
            if ($urandom_range(2) == 0)
                write_reg(8'($urandom_range(2, 255)), $urandom);
            if ($urandom_range(1) == 0)
            begin
                write_reg(skf_pkg::REG_PROCESS_NOISE, pick_noise());
                write_reg(skf_pkg::REG_MEASUREMENT_NOISE, pick_noise());
            end
            else
            begin
                write_reg(skf_pkg::REG_MEASUREMENT_NOISE, pick_noise());
                write_reg(skf_pkg::REG_PROCESS_NOISE, pick_noise());
            end

            // one phase runs with no idling on either side
            src_steady = (phase == 3);
            sink_steady = (phase == 3);

            center = $urandom;
            count = $urandom_range(60, 140);
            for (int unsigned i = 0; i < count; i++)
            begin
                // the sender holds off once mid-phase until everything is back
                if (phase == 5 && i == count / 2)
                    wait_drained();
                send_measurement(pick_measurement(center));
            end
            total += count;
            phase++;
            wait_drained();
        end
        src_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    // result side: compare each output transaction with the oldest prediction
    // and pick the next ready at random
    initial
    begin : result_monitor
        filter_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("unexpected result: estimate %0d gain %0d", estimate, gain);
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (estimate !== want.estimate)
                    begin
                        $error("estimate mismatch: expected %0d, actual %0d",
                               want.estimate, estimate);
                        mismatch_count++;
                    end
                    if (gain !== want.gain)
                    begin
                        $error("gain mismatch: expected %0d, actual %0d", want.gain, gain);
                        mismatch_count++;
                    end
                end
            end
            out_ready <= sink_steady || ($urandom_range(99) >= 37);
        end
    end

    // run limit, well beyond the slowest passing run
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        // predictor matches the register defaults and cleared state after reset
        model_estimate = '0;
        model_covariance = 32'd0;
        model_q = skf_pkg::PROCESS_NOISE_RESET;
        model_r = skf_pkg::MEASUREMENT_NOISE_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_measurement_noise();
        test_zero_divisor();
        test_covariance_saturation();
        test_unknown_index();
        test_random_streams();

        // all predictions are back; let the pipeline settle a little longer
        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
